### rtl/bir_pkg.sv
// Package for the bilinear image resizer: widths, command codes and shared types.
// No dependencies; used by bilinear_image_resize and its testbench.
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;
   localparam int MAX_SRC_WIDTH_DEF  = 256;
   localparam int MAX_SRC_HEIGHT_DEF = 256;
   localparam int MAX_DST_SIDE_DEF   = 4096;
   localparam int CHANNEL_BITS_DEF   = 16;
   localparam int FRAC_BITS_DEF      = 16;

   localparam int SRC_REG_BITS = 9;
   localparam int DST_REG_BITS = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SAMPLE_BITS = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;
endpackage : bir_pkg
`default_nettype wire

### rtl/bilinear_image_resize.sv
// Top level of the bilinear image resizer (aligned corners).
// Depends on bir_pkg, bir_ram and bir_divider.
//
//   channel | ports                              | role
//   req     | req_valid/req_stall, command, rgb  | load or emit request
//   rsp     | rsp_valid/rsp_stall, rgb, end flag | one result per emit
//   csr     | csr_write_en, index, data          | size registers
//
// A load request writes one word of the frame store. An emit runs in order:
// one shared multiplier computes positions, then four single-port store
// reads, then a per-channel blend on the same multiplier; the next request
// can be taken while its result is offered. The first emit of a frame adds
// two serial divisions for the scales. Reset is synchronous; the frame store
// is not cleared. A stalled result holds in the output register; an emit
// that finishes behind it waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_resize
   import bir_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int MAX_DST_SIDE   = bir_pkg::MAX_DST_SIDE_DEF,
   parameter int CHANNEL_BITS   = bir_pkg::CHANNEL_BITS_DEF,
   parameter int FRAC_BITS      = bir_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic [bir_pkg::SAMPLE_BITS-1:0]     req_red_in,
   input  wire logic [bir_pkg::SAMPLE_BITS-1:0]     req_green_in,
   input  wire logic [bir_pkg::SAMPLE_BITS-1:0]     req_blue_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bir_pkg::SAMPLE_BITS-1:0]     rsp_red_out,
   output logic      [bir_pkg::SAMPLE_BITS-1:0]     rsp_green_out,
   output logic      [bir_pkg::SAMPLE_BITS-1:0]     rsp_blue_out,
   output logic                                     rsp_frame_end,
   input  wire logic                                csr_write_en,
   input  wire logic [bir_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bir_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   localparam int DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int SW_BITS  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SH_BITS  = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int SD_BITS  = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
   localparam int DD_BITS  = $clog2(MAX_DST_SIDE + 1);
   localparam int CNT_BITS = $clog2(MAX_DST_SIDE);
   localparam int SCALE_BITS = SD_BITS + FRAC_BITS;
   localparam int NUM_BITS = SCALE_BITS;
   localparam int DEN_BITS = DD_BITS;
   localparam int PIX_BITS = 3 * CHANNEL_BITS;
   localparam int ONE_BITS = FRAC_BITS + 1;
   // Shared multiplier operands: wide enough for position and blend steps.
   localparam int MA_BITS = (SCALE_BITS > CHANNEL_BITS + ONE_BITS)
                          ? SCALE_BITS : CHANNEL_BITS + ONE_BITS;
   localparam int MB_BITS = (CNT_BITS > ONE_BITS) ? CNT_BITS : ONE_BITS;
   localparam int MP_BITS = MA_BITS + MB_BITS;
   localparam int ACC_BITS = CHANNEL_BITS + 2 * FRAC_BITS + 1;
   localparam logic [ONE_BITS-1:0] FRAC_ONE = ONE_BITS'(1) << FRAC_BITS;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'h0001,
      ST_DIVX  = 15'h0002,
      ST_DIVY  = 15'h0004,
      ST_POSX  = 15'h0008,
      ST_POSY  = 15'h0010,
      ST_ADDR  = 15'h0020,
      ST_RD0   = 15'h0040,
      ST_RD1   = 15'h0080,
      ST_RD2   = 15'h0100,
      ST_RD3   = 15'h0200,
      ST_BLEND = 15'h0400,
      ST_LOAD  = 15'h0800,
      ST_OUT   = 15'h1000,
      ST_ROW   = 15'h2000,
      ST_WAIT  = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   // Size registers.
   logic [SRC_REG_BITS-1:0] src_w_ff, src_h_ff;
   logic [DST_REG_BITS-1:0] dst_w_ff, dst_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_REG_BITS'(256);
         src_h_ff <= SRC_REG_BITS'(256);
         dst_w_ff <= DST_REG_BITS'(256);
         dst_h_ff <= DST_REG_BITS'(256);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_w_ff <= csr_data[SRC_REG_BITS-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_data[SRC_REG_BITS-1:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_data[DST_REG_BITS-1:0];
            CSR_DST_HEIGHT: dst_h_ff <= csr_data[DST_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp each size to 1..max.
   logic [SD_BITS-1:0] sw, sh;
   logic [DD_BITS-1:0] dw, dh;
   always_comb begin
      if (src_w_ff == '0) sw = SD_BITS'(1);
      else if (32'(src_w_ff) > MAX_SRC_WIDTH) sw = SD_BITS'(MAX_SRC_WIDTH);
      else sw = SD_BITS'(src_w_ff);
      if (src_h_ff == '0) sh = SD_BITS'(1);
      else if (32'(src_h_ff) > MAX_SRC_HEIGHT) sh = SD_BITS'(MAX_SRC_HEIGHT);
      else sh = SD_BITS'(src_h_ff);
      if (dst_w_ff == '0) dw = DD_BITS'(1);
      else if (32'(dst_w_ff) > MAX_DST_SIDE) dw = DD_BITS'(MAX_DST_SIDE);
      else dw = DD_BITS'(dst_w_ff);
      if (dst_h_ff == '0) dh = DD_BITS'(1);
      else if (32'(dst_h_ff) > MAX_DST_SIDE) dh = DD_BITS'(MAX_DST_SIDE);
      else dh = DD_BITS'(dst_h_ff);
   end

   // Datapath registers.
   logic [ADDR_BITS:0]    load_ptr_ff;
   logic [CNT_BITS-1:0]   col_ff, row_ff;
   logic [SCALE_BITS-1:0] cscale_ff, rscale_ff;
   logic [SD_BITS-1:0]    x0_ff, x1_ff;
   logic [ONE_BITS-1:0]   fx_ff, fy_ff;
   logic [PIX_BITS-1:0]   wdata_ff;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [ADDR_BITS-1:0]  row0_ff, row1_ff;
   logic [PIX_BITS-1:0]   p00_ff, p10_ff, p01_ff;
   logic [1:0]            chan_ff;
   logic [2:0]            step_ff;
   logic [ACC_BITS-1:0]   top_ff, acc_ff;
   logic [MP_BITS-1:0]    prod_ff;
   logic [PIX_BITS-1:0]   res_ff;
   logic [PIX_BITS-1:0]   out_ff;
   logic                  end_ff;
   logic                  rsp_valid_ff;
   logic [PIX_BITS-1:0]   rd_data;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic                  ram_we;

   wire [31:0] total = 32'(sw) * 32'(sh);

   bir_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_store (
      .clock(clock), .write_en(ram_we), .addr(ram_addr),
      .write_data(wdata_ff), .read_data(rd_data));

   // Serial divider for the two scales.
   logic                div_start, div_done;
   logic [NUM_BITS-1:0] div_num, div_q;
   logic [DEN_BITS-1:0] div_den;
   bir_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_q));

   // Shared multiplier, operands chosen by state.
   logic [MA_BITS-1:0] mul_a;
   logic [MB_BITS-1:0] mul_b;
   logic [CHANNEL_BITS-1:0] c00, c10, c01, c11;
   logic [ONE_BITS-1:0] fw;
   always_comb begin
      c00 = p00_ff[chan_ff*CHANNEL_BITS +: CHANNEL_BITS];
      c10 = p10_ff[chan_ff*CHANNEL_BITS +: CHANNEL_BITS];
      c01 = p01_ff[chan_ff*CHANNEL_BITS +: CHANNEL_BITS];
      c11 = rd_data[chan_ff*CHANNEL_BITS +: CHANNEL_BITS];
      mul_a = '0;
      mul_b = '0;
      fw = '0;
      case (state_ff)
         ST_POSX: begin
            mul_a = MA_BITS'(cscale_ff);
            mul_b = MB_BITS'(col_ff);
         end
         ST_POSY: begin
            mul_a = MA_BITS'(rscale_ff);
            mul_b = MB_BITS'(row_ff);
         end
         ST_BLEND: begin
            // Steps: c00*(1-fx), c10*fx, c01*(1-fx), c11*fx, top*(1-fy), bot*fy.
            case (step_ff)
               3'd0: begin mul_a = MA_BITS'(c00); fw = FRAC_ONE - fx_ff; end
               3'd1: begin mul_a = MA_BITS'(c10); fw = fx_ff; end
               3'd2: begin mul_a = MA_BITS'(c01); fw = FRAC_ONE - fx_ff; end
               3'd3: begin mul_a = MA_BITS'(c11); fw = fx_ff; end
               3'd4: begin
                  mul_a = MA_BITS'(top_ff[CHANNEL_BITS+FRAC_BITS:0]);
                  fw = FRAC_ONE - fy_ff;
               end
               default: begin
                  mul_a = MA_BITS'(acc_ff[CHANNEL_BITS+FRAC_BITS:0]);
                  fw = fy_ff;
               end
            endcase
            mul_b = MB_BITS'(fw);
         end
         default: ;
      endcase
   end
   wire [MP_BITS-1:0] mul_p = MP_BITS'(mul_a) * MP_BITS'(mul_b);

   // Position split: near, far and fraction from a registered product.
   logic [SD_BITS-1:0]  lo_v, hi_v, size_v;
   logic [ONE_BITS-1:0] frac_v;
   logic [MP_BITS-1:0]  ip_v;
   always_comb begin
      size_v = (state_ff == ST_POSY) ? sw : sh;
      ip_v   = prod_ff >> FRAC_BITS;
      frac_v = ONE_BITS'(prod_ff[FRAC_BITS-1:0]);
      if (ip_v >= MP_BITS'(size_v - 1'b1)) begin
         lo_v = size_v - 1'b1;
         if (ip_v > MP_BITS'(size_v - 1'b1)) frac_v = '0;
      end else begin
         lo_v = SD_BITS'(ip_v);
      end
      hi_v = (lo_v + 1'b1 < size_v) ? lo_v + 1'b1 : size_v - 1'b1;
   end

   wire last_col = (32'(col_ff) + 1) >= 32'(dw);
   wire last_row = (32'(row_ff) + 1) >= 32'(dh);
   wire accept = req_valid && !req_stall;
   wire rsp_take = rsp_valid_ff && !rsp_stall;
   // A finished pixel moves to the output register once it is free.
   wire out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_take);

   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = (state_ff == ST_IDLE && accept && req_command == CMD_EMIT
                       && col_ff == '0 && row_ff == '0)
                    || (state_ff == ST_DIVX && div_done);
   assign div_num = (state_ff == ST_DIVX)
                  ? NUM_BITS'(sh - 1'b1) << FRAC_BITS
                  : NUM_BITS'(sw - 1'b1) << FRAC_BITS;
   assign div_den = (state_ff == ST_DIVX) ? DEN_BITS'(dh - 1'b1) : DEN_BITS'(dw - 1'b1);

   // Store port: write on load, otherwise read at the sequenced address.
   assign ram_we = (state_ff == ST_LOAD);
   assign ram_addr = ram_we ? load_ptr_ff[ADDR_BITS-1:0] : addr_ff;

   // Read addresses: row bases y*sw are formed when the row is split.
   always_comb begin
      addr_in = addr_ff;
      case (state_ff)
         ST_ADDR: addr_in = row0_ff + ADDR_BITS'(x0_ff);
         ST_RD0:  addr_in = row0_ff + ADDR_BITS'(x1_ff);
         ST_RD1:  addr_in = row1_ff + ADDR_BITS'(x0_ff);
         ST_RD2:  addr_in = row1_ff + ADDR_BITS'(x1_ff);
         default: ;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LOAD) state_in = ST_LOAD;
               else if (col_ff == '0 && row_ff == '0) state_in = ST_DIVX;
               else state_in = ST_POSX;
            end
         end
         ST_DIVX:  if (div_done) state_in = ST_DIVY;
         ST_DIVY:  if (div_done) state_in = ST_POSX;
         ST_POSX:  state_in = ST_POSY;
         ST_POSY:  state_in = ST_ROW;
         ST_ROW:   state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_RD0;
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_RD2;
         ST_RD2:   state_in = ST_RD3;
         ST_RD3:   state_in = ST_WAIT;
         ST_WAIT:  state_in = ST_BLEND;
         ST_BLEND: if (chan_ff == 2'd2 && step_ff == 3'd6) state_in = ST_OUT;
         ST_LOAD:  state_in = ST_IDLE;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   wire [ACC_BITS-1:0] half = ACC_BITS'(1) << (2 * FRAC_BITS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ptr_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cscale_ff    <= '0;
         rscale_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         chan_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_command == CMD_LOAD) begin
                  if (32'(load_ptr_ff) >= total) load_ptr_ff <= '0;
               end
            end
            ST_LOAD: begin
               load_ptr_ff <= (32'(load_ptr_ff) + 1 >= total)
                            ? '0 : load_ptr_ff + 1'b1;
            end
            ST_DIVX: if (div_done) cscale_ff <= (dw <= DD_BITS'(1)) ? '0 : div_q;
            ST_DIVY: if (div_done) rscale_ff <= (dh <= DD_BITS'(1)) ? '0 : div_q;
            ST_ADDR: begin
               chan_ff <= '0;
               step_ff <= '0;
            end
            ST_BLEND: begin
               if (step_ff == 3'd6) begin
                  step_ff <= '0;
                  chan_ff <= chan_ff + 1'b1;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  if (last_col) begin
                     col_ff <= '0;
                     row_ff <= last_row ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      // Payload registers.
      if (state_ff == ST_IDLE) begin
         wdata_ff <= {PIX_BITS'(req_blue_in[CHANNEL_BITS-1:0]) << (2 * CHANNEL_BITS)}
                   | {PIX_BITS'(req_green_in[CHANNEL_BITS-1:0]) << CHANNEL_BITS}
                   | PIX_BITS'(req_red_in[CHANNEL_BITS-1:0]);
      end
      prod_ff <= mul_p;
      addr_ff <= addr_in;
      if (state_ff == ST_POSY) begin
         x0_ff <= lo_v;
         x1_ff <= hi_v;
         fx_ff <= frac_v;
      end
      if (state_ff == ST_ROW) begin
         fy_ff <= frac_v;
         row0_ff <= ADDR_BITS'(32'(lo_v) * 32'(sw));
         row1_ff <= ADDR_BITS'(32'(hi_v) * 32'(sw));
      end
      if (state_ff == ST_RD1) p00_ff <= rd_data;
      if (state_ff == ST_RD2) p10_ff <= rd_data;
      if (state_ff == ST_RD3) p01_ff <= rd_data;
      if (state_ff == ST_WAIT) p01_ff <= p01_ff;
      if (state_ff == ST_BLEND) begin
         case (step_ff)
            3'd1: top_ff <= ACC_BITS'(prod_ff);
            3'd2: top_ff <= top_ff + ACC_BITS'(prod_ff);
            3'd3: acc_ff <= ACC_BITS'(prod_ff);
            3'd4: acc_ff <= acc_ff + ACC_BITS'(prod_ff);
            3'd5: top_ff <= ACC_BITS'(prod_ff) + half;
            3'd6: res_ff[chan_ff*CHANNEL_BITS +: CHANNEL_BITS]
                     <= CHANNEL_BITS'((top_ff + ACC_BITS'(prod_ff)) >> (2 * FRAC_BITS));
            default: ;
         endcase
      end
      if (out_load) begin
         out_ff <= res_ff;
         end_ff <= last_col && last_row;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = SAMPLE_BITS'(out_ff[CHANNEL_BITS-1:0]);
   assign rsp_green_out = SAMPLE_BITS'(out_ff[2*CHANNEL_BITS-1:CHANNEL_BITS]);
   assign rsp_blue_out  = SAMPLE_BITS'(out_ff[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
   assign rsp_frame_end = end_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("request taken while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid_ff) else $error("result not raised");
   a_store_ptr: assert property (@(posedge clock) disable iff (reset)
      32'(load_ptr_ff) <= DEPTH) else $error("load pointer out of range");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
`endif
endmodule : bilinear_image_resize
`default_nettype wire

### rtl/bir_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bir_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One access per cycle: an optional write plus a registered read of the old word.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= write_data;
      end
      read_data <= mem[addr];
   end
endmodule : bir_ram
`default_nettype wire

### rtl/bir_divider.sv
// Restoring divider producing one quotient bit per cycle, used for the scales.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none
module bir_divider #(
   parameter int NUM_BITS = 28,
   parameter int DEN_BITS = 14
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numerator,
   input  wire logic [DEN_BITS-1:0] denominator,
   output logic                     done,
   output logic      [NUM_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DEN_BITS+1:0] trial;
   logic [NUM_BITS-1:0] quo_step;

   // One shift-subtract step per cycle.
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, quo_ff[NUM_BITS-1]} - {2'b00, den_ff};
      quo_step = {quo_ff[NUM_BITS-2:0], ~trial[DEN_BITS+1]};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_BITS+1]) begin
            rem_in = trial[DEN_BITS:0];
         end else begin
            rem_in = {rem_ff[DEN_BITS-1:0], quo_ff[NUM_BITS-1]};
         end
         quo_in  = quo_step;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // The final step's quotient is valid while done is high, even if a new
   // division starts at the same edge.
   assign done     = busy_ff && (cnt_ff == CNT_BITS'(1));
   assign quotient = quo_step;
endmodule : bir_divider
`default_nettype wire

### tb/bilinear_image_resize_tb.sv
// Self-checking testbench for bilinear_image_resize: loads small frames, emits
// resized pixels and compares them with a built-in bilinear predictor.
// Depends on bir_pkg and the RTL of bilinear_image_resize.
`timescale 1ns / 1ps

module bilinear_image_resize_tb;
   import bir_pkg::*;

   localparam int FRAC = 16;
   localparam longint unsigned ONE = 64'd1 << FRAC;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 100;

   // Predicted destination pixel.
   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last;
   } pixel_type;

   // Scoreboard: mirrors the resizer state and holds the pixels still owed.
   class resize_scoreboard;
      bit [47:0]   frame_mem [65536];
      int unsigned reg_sw, reg_sh, reg_dw, reg_dh;
      int unsigned load_ptr, col, row;
      longint unsigned col_step, row_step;
      pixel_type   owed [$];
      int          mismatches, results;

      function new();
         reg_sw = 256; reg_sh = 256; reg_dw = 256; reg_dh = 256;
         load_ptr = 0; col = 0; row = 0; col_step = 0; row_step = 0;
         mismatches = 0; results = 0;
      endfunction

      function void set_size(csr_index_type idx, int unsigned val);
         case (idx)
            CSR_SRC_WIDTH: reg_sw = val & 'h1FF;
            CSR_SRC_HEIGHT: reg_sh = val & 'h1FF;
            CSR_DST_WIDTH: reg_dw = val & 'h1FFF;
            default: reg_dh = val & 'h1FFF;
         endcase
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned top);
         if (v == 0) return 1;
         return (v > top) ? top : v;
      endfunction

      function longint unsigned step_of(int unsigned src, int unsigned dst);
         if (dst <= 1) return 0;
         return (longint'(src - 1) << FRAC) / longint'(dst - 1);
      endfunction

      // Near neighbor, far neighbor and fraction along one axis.
      function void split(int unsigned idx, longint unsigned stp, int unsigned size,
                          output int unsigned lo, output int unsigned hi,
                          output longint unsigned fr);
         longint unsigned pos, ip;
         pos = longint'(idx) * stp;
         ip = pos >> FRAC;
         fr = pos & (ONE - 1);
         if (ip >= size - 1) begin
            lo = size - 1;
            if (ip > size - 1) fr = 0;
         end else begin
            lo = 32'(ip);
         end
         hi = (lo + 1 < size) ? lo + 1 : size - 1;
      endfunction

      function logic [15:0] mix(longint unsigned a, longint unsigned b,
                                longint unsigned c, longint unsigned d,
                                longint unsigned fx, longint unsigned fy);
         longint unsigned top, bot, acc;
         top = a * (ONE - fx) + b * fx;
         bot = c * (ONE - fx) + d * fx;
         acc = top * (ONE - fy) + bot * fy + (64'd1 << (2 * FRAC - 1));
         return 16'(acc >> (2 * FRAC));
      endfunction

      // Update the mirror for an accepted request; an emit queues one pixel.
      function void note_request(logic cmd, logic [15:0] r, logic [15:0] g,
                                 logic [15:0] b);
         int unsigned sw, sh, dw, dh, total, p, x0, x1, y0, y1;
         longint unsigned fx, fy;
         bit [47:0] p00, p10, p01, p11;
         pixel_type px;
         sw = clamp(reg_sw, 256); sh = clamp(reg_sh, 256);
         dw = clamp(reg_dw, 4096); dh = clamp(reg_dh, 4096);
         total = sw * sh;
         if (cmd == CMD_LOAD) begin
            p = (load_ptr < total) ? load_ptr : 0;
            frame_mem[p] = {r, g, b};
            load_ptr = (p + 1 >= total) ? 0 : p + 1;
            return;
         end
         // Scales latch at the first pixel of each destination frame.
         if (col == 0 && row == 0) begin
            col_step = step_of(sw, dw);
            row_step = step_of(sh, dh);
         end
         split(col, col_step, sw, x0, x1, fx);
         split(row, row_step, sh, y0, y1, fy);
         p00 = frame_mem[y0 * sw + x0]; p10 = frame_mem[y0 * sw + x1];
         p01 = frame_mem[y1 * sw + x0]; p11 = frame_mem[y1 * sw + x1];
         px.red   = mix(p00[47:32], p10[47:32], p01[47:32], p11[47:32], fx, fy);
         px.green = mix(p00[31:16], p10[31:16], p01[31:16], p11[31:16], fx, fy);
         px.blue  = mix(p00[15:0], p10[15:0], p01[15:0], p11[15:0], fx, fy);
         px.last  = (col + 1 >= dw) && (row + 1 >= dh);
         if (col + 1 >= dw) begin
            col = 0;
            row = (row + 1 >= dh) ? 0 : row + 1;
         end else begin
            col++;
         end
         owed = {owed, px};
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         results++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected pixel r=%h g=%h b=%h end=%b",
                        got.red, got.green, got.blue, got.last);
            return;
         end
         want = owed.pop_front();
         if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Pixel %0d: expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                        results, want.red, want.green, want.blue, want.last,
                        got.red, got.green, got.blue, got.last);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_stall, req_command;
   logic [15:0] req_red_in, req_green_in, req_blue_in;
   logic        rsp_valid, rsp_stall, rsp_frame_end;
   logic [15:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   resize_scoreboard sb = new();
   int  cycles = 0;
   int  requests = 0;
   int  phases = 0;
   bit  calm = 0;

   bilinear_image_resize DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_frame_end(rsp_frame_end),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Cycle counter with a hard limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Check every accepted pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end});
   end

   // Receiver back-pressure: a random stall, possibly none, ahead of each pixel.
   initial begin
      int n;
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         n = calm ? 0 : $urandom_range(0, 14);
         if (n > 0) begin
            rsp_stall = 1;
            repeat (n) @(negedge clock);
            rsp_stall = 0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic write_size(csr_index_type idx, int unsigned val);
      csr_write_en = 1;
      csr_index = idx;
      csr_data = CSR_DATA_BITS'(val);
      sb.set_size(idx, val);
      @(negedge clock);
      csr_write_en = 0;
   endtask

   // Drive one request; valid stays high between back-to-back requests.
   task automatic send_request(logic cmd, logic [15:0] r, logic [15:0] g,
                               logic [15:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_command = cmd;
      req_red_in = r; req_green_in = g; req_blue_in = b;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, r, g, b);
      requests++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One phase: set sizes, fill the whole source frame, then mix loads and emits.
   task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                            int unsigned dh, int extra, int emit_pct, bit corners);
      int unsigned total;
      logic [15:0] v;
      wait_idle();
      write_size(CSR_SRC_WIDTH, sw);
      write_size(CSR_SRC_HEIGHT, sh);
      write_size(CSR_DST_WIDTH, dw);
      write_size(CSR_DST_HEIGHT, dh);
      total = sb.clamp(sw, 256) * sb.clamp(sh, 256);
      phases++;
      for (int i = 0; i < total; i++) begin
         v = (i % 2) ? 16'hFFFF : 16'h0000;
         if (corners) send_request(CMD_LOAD, v, ~v, v);
         else send_request(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      for (int i = 0; i < extra; i++) begin
         if ($urandom_range(0, 99) < emit_pct)
            send_request(CMD_EMIT, 16'($urandom), 16'($urandom), 16'($urandom));
         else send_request(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      int pick;
      bit wide_done, tall_done;
      int unsigned sw, sh, dw, dh;
      reset = 1;
      req_valid = 0; req_command = CMD_LOAD;
      req_red_in = 0; req_green_in = 0; req_blue_in = 0;
      csr_write_en = 0; csr_index = CSR_SRC_WIDTH; csr_data = 0;
      wide_done = 0; tall_done = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: zero sizes read as one, sample extremes, single-column output.
      run_phase(0, 0, 0, 0, 3, 100, 1);
      run_phase(2, 2, 3, 3, 9, 100, 1);
      run_phase(3, 2, 1, 2, 4, 100, 1);

      // Random phases; sizes shrink and grow so counters and pointer overrun.
      while (requests < 650) begin
         calm = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 9);
         sw = $urandom_range(1, 6); sh = $urandom_range(1, 6);
         dw = $urandom_range(1, 12); dh = $urandom_range(1, 12);
         if (pick == 0 && !wide_done && requests < 300) begin
            wide_done = 1; sw = 511; sh = 1; dw = 8191;
         end else if (pick == 1 && !tall_done && requests < 300) begin
            tall_done = 1; sw = 1; sh = 256; dh = 4096;
         end else if (pick == 2) begin
            sw = $urandom_range(0, 8); sh = $urandom_range(0, 8);
            dw = ($urandom_range(0, 1)) ? 0 : 4096;
            dh = ($urandom_range(0, 2) == 0) ? 8191 : $urandom_range(0, 3);
         end
         run_phase(sw, sh, dw, dh, $urandom_range(20, 40), 75, 0);
      end

      wait_idle();
      $display("Ran %0d phases, %0d requests, %0d pixels checked.",
               phases, requests, sb.results);
      if (sb.owed.size() != 0) sb.mismatches += sb.owed.size();
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d errors", sb.mismatches);
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
